FILE: hdl/ecs_pkg.sv
// Types and codes shared by the elevator call scheduler.
// Payload structs for the request and status channels, command, direction
// and event codes, register indexes and reset values. No dependencies.
`default_nettype none

package ecs_pkg;

    localparam int FLOOR_W    = 5;
    localparam int FLOORS_MAX = 16;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_CAR   = 3'd1;
    localparam logic [2:0] CMD_HALL  = 3'd2;
    localparam logic [2:0] CMD_OPEN  = 3'd3;
    localparam logic [2:0] CMD_CLOSE = 3'd4;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DEP_UP   = 3'd1;
    localparam logic [2:0] EV_DEP_DOWN = 3'd2;
    localparam logic [2:0] EV_STOP     = 3'd3;
    localparam logic [2:0] EV_ARRIVE   = 3'd4;
    localparam logic [2:0] EV_OPEN     = 3'd5;
    localparam logic [2:0] EV_CLOSE    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOOR_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_FLOOR = 2'd2;

    localparam logic [TICK_W-1:0] MOVE_TICKS_RST = 8'd5;
    localparam logic [TICK_W-1:0] DOOR_TICKS_RST = 8'd5;
    localparam int                HOME_FLOOR_RST = 3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [FLOOR_W-1:0] req_floor;
        logic               hall_dir;
    } ecs_in_t;

    typedef struct packed {
        logic [FLOOR_W-1:0]    cur_floor;
        logic [1:0]            travel_dir;
        logic                  door_is_open;
        logic                  in_motion;
        logic [FLOORS_MAX-1:0] up_pending;
        logic [FLOORS_MAX-1:0] down_pending;
        logic [2:0]            event_res;
    } ecs_out_t;

    typedef struct packed {
        logic                  wr;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } ecs_cfg_wr_t;

endpackage

`default_nettype wire

FILE: hdl/ecs_core.sv
// Car state, configuration registers and the per-beat scheduling step.
// Produces the status that follows each accepted beat. Uses ecs_pkg.
`default_nettype none

module ecs_core #(
    parameter int FLOORS = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire ecs_pkg::ecs_in_t    item,
    input  wire ecs_pkg::ecs_cfg_wr_t cfg,
    output ecs_pkg::ecs_out_t        result
);
    import ecs_pkg::*;

    localparam int FW = $clog2(FLOORS + 1);
    localparam logic [FW-1:0] HOME_RST =
        FW'((HOME_FLOOR_RST > FLOORS) ? FLOORS : HOME_FLOOR_RST);
    localparam logic [FLOORS-1:0] ONE_BIT = FLOORS'(1);

    typedef enum logic [1:0] {PH_IDLE, PH_MOVE, PH_DOOR} phase_t;

    logic [TICK_W-1:0] move_ticks_reg, door_ticks_reg;
    logic [FLOORS-1:0] up_reg, down_reg, up_next, down_next;
    logic [FW-1:0]     car_reg, car_next, car_step;
    logic [1:0]        dir_reg, dir_next;
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] timer_reg, timer_next;
    logic              open_reg, open_next, close_reg, close_next;
    logic [2:0]        ev;

    logic [TICK_W:0]     timer_inc;
    logic [FLOORS-1:0]   car_bit, car_le, car_ge, f_bit, f_le, f_ge;
    logic                up_here, up_above, down_here, down_below;
    logic                f_ok, f_gt_car, f_ge_car, up_over_f, down_under_f, to_up;
    logic [FLOOR_W-1:0]  car_ext, cfg_floor;
    logic [FW-1:0]       home_clamped;

    assign timer_inc = {1'b0, timer_reg} + {{TICK_W{1'b0}}, 1'b1};
    assign car_ext   = FLOOR_W'(car_reg);
    assign car_bit   = ONE_BIT << (car_reg - FW'(1));
    assign car_le    = (car_bit << 1) - ONE_BIT;
    assign car_ge    = ~(car_bit - ONE_BIT);
    assign up_here    = |(up_reg & car_bit);
    assign up_above   = |(up_reg & car_ge & ~car_bit);
    assign down_here  = |(down_reg & car_bit);
    assign down_below = |(down_reg & car_le & ~car_bit);

    assign f_ok  = (item.req_floor >= FLOOR_W'(1)) && (item.req_floor <= FLOOR_W'(FLOORS));
    assign f_bit = ONE_BIT << (item.req_floor - FLOOR_W'(1));
    assign f_le  = (f_bit << 1) - ONE_BIT;
    assign f_ge  = ~(f_bit - ONE_BIT);
    assign f_gt_car     = item.req_floor > car_ext;
    assign f_ge_car     = item.req_floor >= car_ext;
    assign up_over_f    = |(up_reg & f_ge & ~f_bit);
    assign down_under_f = |(down_reg & f_le & ~f_bit);

    assign cfg_floor    = cfg.data[FLOOR_W-1:0];
    assign home_clamped = (cfg_floor == '0) ? FW'(1) :
                          (cfg_floor > FLOOR_W'(FLOORS)) ? FW'(FLOORS) : FW'(cfg_floor);

    always_comb begin
        to_up = f_ge_car;
        if (item.cmd == CMD_CAR) begin
            to_up = (dir_reg == DIR_DOWN) ? f_gt_car : f_ge_car;
        end else begin
            case (dir_reg)
                DIR_UP:   to_up = item.hall_dir ? !up_over_f : f_ge_car;
                DIR_DOWN: to_up = item.hall_dir ? f_gt_car : down_under_f;
                default:  to_up = f_ge_car;
            endcase
        end
    end

    always_comb begin
        up_next    = up_reg;
        down_next  = down_reg;
        car_step   = car_reg;
        dir_next   = dir_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        open_next  = open_reg;
        close_next = close_reg;
        ev         = EV_NONE;
        if (step_en) begin
            case (item.cmd)
                CMD_TICK: begin
                    case (phase_reg)
                        PH_MOVE: begin
                            if (timer_inc >= {1'b0, move_ticks_reg}) begin
                                phase_next = PH_IDLE;
                                timer_next = '0;
                                if (dir_reg == DIR_UP) begin
                                    if (car_reg >= FW'(FLOORS)) dir_next = DIR_STOP;
                                    else car_step = car_reg + FW'(1);
                                end else if (dir_reg == DIR_DOWN) begin
                                    if (car_reg <= FW'(1)) dir_next = DIR_STOP;
                                    else car_step = car_reg - FW'(1);
                                end
                            end else begin
                                timer_next = timer_inc[TICK_W-1:0];
                            end
                        end
                        PH_DOOR: begin
                            if (open_reg) begin
                                open_next  = 1'b0;
                                timer_next = '0;
                            end else if (close_reg) begin
                                close_next = 1'b0;
                                phase_next = PH_IDLE;
                                timer_next = '0;
                                ev         = EV_CLOSE;
                            end else if (timer_inc >= {1'b0, door_ticks_reg}) begin
                                phase_next = PH_IDLE;
                                timer_next = '0;
                                ev         = EV_CLOSE;
                            end else begin
                                timer_next = timer_inc[TICK_W-1:0];
                            end
                        end
                        default: begin
                            case (dir_reg)
                                DIR_UP: begin
                                    if (up_here) begin
                                        up_next    = up_reg & ~car_bit;
                                        phase_next = PH_DOOR;
                                        timer_next = '0;
                                        open_next  = 1'b0;
                                        ev         = EV_ARRIVE;
                                    end else if (up_above) begin
                                        phase_next = PH_MOVE;
                                        timer_next = '0;
                                        ev         = EV_DEP_UP;
                                    end else begin
                                        dir_next = DIR_STOP;
                                        ev       = EV_STOP;
                                    end
                                end
                                DIR_DOWN: begin
                                    if (down_here) begin
                                        down_next  = down_reg & ~car_bit;
                                        phase_next = PH_DOOR;
                                        timer_next = '0;
                                        open_next  = 1'b0;
                                        ev         = EV_ARRIVE;
                                    end else if (down_below) begin
                                        phase_next = PH_MOVE;
                                        timer_next = '0;
                                        ev         = EV_DEP_DOWN;
                                    end else begin
                                        dir_next = DIR_STOP;
                                        ev       = EV_STOP;
                                    end
                                end
                                default: begin
                                    dir_next = DIR_STOP;
                                    if (open_reg) begin
                                        phase_next = PH_DOOR;
                                        timer_next = '0;
                                        open_next  = 1'b0;
                                        ev         = EV_OPEN;
                                    end else if (up_here) begin
                                        up_next    = up_reg & ~car_bit;
                                        phase_next = PH_DOOR;
                                        timer_next = '0;
                                        ev         = EV_ARRIVE;
                                    end else if (up_above) begin
                                        dir_next   = DIR_UP;
                                        phase_next = PH_MOVE;
                                        timer_next = '0;
                                        ev         = EV_DEP_UP;
                                    end else if (down_here) begin
                                        down_next  = down_reg & ~car_bit;
                                        phase_next = PH_DOOR;
                                        timer_next = '0;
                                        ev         = EV_ARRIVE;
                                    end else if (down_below) begin
                                        dir_next   = DIR_DOWN;
                                        phase_next = PH_MOVE;
                                        timer_next = '0;
                                        ev         = EV_DEP_DOWN;
                                    end
                                end
                            endcase
                        end
                    endcase
                end
                CMD_CAR, CMD_HALL: begin
                    if (f_ok) begin
                        if (to_up) up_next = up_reg | f_bit;
                        else down_next = down_reg | f_bit;
                    end
                end
                CMD_OPEN:  open_next  = 1'b1;
                CMD_CLOSE: close_next = 1'b1;
                default: ;
            endcase
        end
    end

    assign car_next = (cfg.wr && cfg.index == REG_HOME_FLOOR && phase_reg == PH_IDLE) ?
                      home_clamped : car_step;

    always_comb begin
        result.cur_floor    = FLOOR_W'(car_step);
        result.travel_dir   = dir_next;
        result.door_is_open = phase_next == PH_DOOR;
        result.in_motion    = phase_next == PH_MOVE;
        result.up_pending   = FLOORS_MAX'(up_next);
        result.down_pending = FLOORS_MAX'(down_next);
        result.event_res    = ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_ticks_reg <= MOVE_TICKS_RST;
            door_ticks_reg <= DOOR_TICKS_RST;
            up_reg         <= '0;
            down_reg       <= '0;
            car_reg        <= HOME_RST;
            dir_reg        <= DIR_STOP;
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            open_reg       <= 1'b0;
            close_reg      <= 1'b0;
        end else begin
            up_reg    <= up_next;
            down_reg  <= down_next;
            car_reg   <= car_next;
            dir_reg   <= dir_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            open_reg  <= open_next;
            close_reg <= close_next;
            if (cfg.wr) begin
                case (cfg.index)
                    REG_MOVE_TICKS: move_ticks_reg <= (cfg.data == '0) ? TICK_W'(1) : cfg.data;
                    REG_DOOR_TICKS: door_ticks_reg <= (cfg.data == '0) ? TICK_W'(1) : cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/elevator_call_scheduler_unit.sv
// Elevator call scheduler top level: request, status and register channels.
// Depends on ecs_pkg and ecs_core.
//
// Usage
//   s_valid/s_ready/s_data carry one command beat: tick, car request, hall
//   call, open button or close button. Every accepted beat yields exactly one
//   status beat on m_valid/m_ready/m_data with the car floor, direction, door
//   and motion flags, both pending-stop bitmaps and the event of that beat.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write move_ticks (0), door_ticks
//   (1) and home_floor (2); cfg_ready is always high. Write only while no
//   status beat is outstanding.
//   The status beat is valid the cycle after the command is accepted.
//   Throughput is one beat per cycle while m_ready stays high, set by
//   the single scheduling step between the state and status registers.
//   When the receiver stalls, the status register holds and s_ready drops;
//   a new beat is taken in the same cycle the held one is taken.
//   After aresetn the car is idle on the home floor with no pending stops and
//   the registers hold their defaults; no result is pending.
`default_nettype none

module elevator_call_scheduler_unit #(
    parameter int FLOORS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire ecs_pkg::ecs_in_t                   s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output ecs_pkg::ecs_out_t                       m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ecs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ecs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ecs_pkg::*;

    logic        m_valid_reg;
    ecs_out_t    m_data_reg;
    ecs_out_t    step_result;
    ecs_cfg_wr_t cfg_wr;
    logic        step_en;

    assign s_ready   = !m_valid_reg || m_ready;
    assign step_en   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = '{wr: cfg_valid, index: cfg_index, data: cfg_data};

    ecs_core #(
        .FLOORS(FLOORS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (s_data),
        .cfg     (cfg_wr),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_data_reg <= step_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: bench/tb_elevator_call_scheduler_unit.sv
// Self-checking bench for elevator_call_scheduler_unit: request, status and register channels.
// Predicts each status beat from its own car model; depends on ecs_pkg and the unit.
// Runs directed beats, then random phases under several register settings and idle mixes.
module tb_elevator_call_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ecs_pkg::*;

    localparam int NUM_FLOORS   = 8;
    localparam int STALL_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_CAP   = 40;

    typedef enum logic [1:0] {CAR_IDLE, CAR_MOVING, CAR_DOOR} car_phase_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    ecs_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    ecs_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ecs_in_t  beat_q[$];
    ecs_out_t status_q[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_request  = 0;
    int stall_served   = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // car model
    logic [NUM_FLOORS-1:0] up_map;
    logic [NUM_FLOORS-1:0] down_map;
    int         car_at;
    logic [1:0] heading;
    car_phase_t car_phase;
    int         phase_cnt;
    bit         open_held;
    bit         close_held;
    int         travel_ticks;
    int         dwell_ticks;
    int         home_at;

    elevator_call_scheduler_unit #(.FLOORS(NUM_FLOORS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int clamp_floor(input int f);
        if (f < 1) return 1;
        if (f > NUM_FLOORS) return NUM_FLOORS;
        return f;
    endfunction

    function automatic void reset_car();
        travel_ticks = int'(MOVE_TICKS_RST);
        dwell_ticks  = int'(DOOR_TICKS_RST);
        home_at      = clamp_floor(HOME_FLOOR_RST);
        up_map       = '0;
        down_map     = '0;
        car_at       = home_at;
        heading      = DIR_STOP;
        car_phase    = CAR_IDLE;
        phase_cnt    = 0;
        open_held    = 1'b0;
        close_held   = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MOVE_TICKS: begin
                travel_ticks = (val == 0) ? 1 : int'(val);
            end
            REG_DOOR_TICKS: begin
                dwell_ticks = (val == 0) ? 1 : int'(val);
            end
            REG_HOME_FLOOR: begin
                home_at = clamp_floor(int'(val[FLOOR_W-1:0]));
                if (car_phase == CAR_IDLE) car_at = home_at;
            end
            default: ;
        endcase
    endfunction

    function automatic void file_stop(input int f, input bit to_up);
        if (to_up) up_map[f-1] = 1'b1;
        else down_map[f-1] = 1'b1;
    endfunction

    // lowest up stop at or above the car, 0 if none
    function automatic int lowest_up_ahead();
        int n;
        n = 0;
        for (int f = NUM_FLOORS; f >= car_at; f--)
            if (up_map[f-1]) n = f;
        return n;
    endfunction

    // highest down stop at or below the car, 0 if none
    function automatic int highest_down_ahead();
        int n;
        n = 0;
        for (int f = 1; f <= car_at; f++)
            if (down_map[f-1]) n = f;
        return n;
    endfunction

    function automatic logic [2:0] open_car_door(input logic [2:0] ev);
        car_phase = CAR_DOOR;
        phase_cnt = 0;
        open_held = 1'b0;
        return ev;
    endfunction

    function automatic logic [2:0] start_travel(input logic [1:0] dir);
        heading   = dir;
        car_phase = CAR_MOVING;
        phase_cnt = 0;
        return (dir == DIR_UP) ? EV_DEP_UP : EV_DEP_DOWN;
    endfunction

    function automatic logic [2:0] tick_car();
        int n;
        if (car_phase == CAR_MOVING) begin
            phase_cnt++;
            if (phase_cnt >= travel_ticks) begin
                car_phase = CAR_IDLE;
                phase_cnt = 0;
                if (heading == DIR_UP) begin
                    if (car_at >= NUM_FLOORS) heading = DIR_STOP;
                    else car_at++;
                end else if (heading == DIR_DOWN) begin
                    if (car_at <= 1) heading = DIR_STOP;
                    else car_at--;
                end
            end
            return EV_NONE;
        end
        if (car_phase == CAR_DOOR) begin
            if (open_held) begin
                open_held = 1'b0;
                phase_cnt = 0;
                return EV_NONE;
            end
            if (close_held) begin
                close_held = 1'b0;
                car_phase  = CAR_IDLE;
                phase_cnt  = 0;
                return EV_CLOSE;
            end
            phase_cnt++;
            if (phase_cnt >= dwell_ticks) begin
                car_phase = CAR_IDLE;
                phase_cnt = 0;
                return EV_CLOSE;
            end
            return EV_NONE;
        end
        if (heading == DIR_UP) begin
            n = lowest_up_ahead();
            if (n == car_at) begin
                up_map[n-1] = 1'b0;
                return open_car_door(EV_ARRIVE);
            end
            if (n > car_at) return start_travel(DIR_UP);
            heading = DIR_STOP;
            return EV_STOP;
        end
        if (heading == DIR_DOWN) begin
            n = highest_down_ahead();
            if (n == car_at) begin
                down_map[n-1] = 1'b0;
                return open_car_door(EV_ARRIVE);
            end
            if (n >= 1) return start_travel(DIR_DOWN);
            heading = DIR_STOP;
            return EV_STOP;
        end
        heading = DIR_STOP;
        if (open_held) return open_car_door(EV_OPEN);
        n = lowest_up_ahead();
        if (n == car_at) begin
            up_map[n-1] = 1'b0;
            return open_car_door(EV_ARRIVE);
        end
        if (n > car_at) return start_travel(DIR_UP);
        n = highest_down_ahead();
        if (n == car_at) begin
            down_map[n-1] = 1'b0;
            return open_car_door(EV_ARRIVE);
        end
        if (n >= 1) return start_travel(DIR_DOWN);
        return EV_NONE;
    endfunction

    function automatic ecs_out_t advance_car(input ecs_in_t beat);
        ecs_out_t   st;
        logic [2:0] ev;
        int         f;
        int         top;
        int         bot;
        bit         f_ok;
        ev   = EV_NONE;
        f    = int'(beat.req_floor);
        f_ok = (f >= 1) && (f <= NUM_FLOORS);
        case (beat.cmd)
            CMD_TICK: begin
                ev = tick_car();
            end
            CMD_CAR: begin
                if (f_ok) begin
                    if (heading == DIR_DOWN) file_stop(f, !(f <= car_at));
                    else file_stop(f, f >= car_at);
                end
            end
            CMD_HALL: begin
                if (f_ok) begin
                    if (heading == DIR_UP) begin
                        if (!beat.hall_dir) begin
                            file_stop(f, f >= car_at);
                        end else begin
                            top = 0;
                            for (int g = 1; g <= NUM_FLOORS; g++)
                                if (up_map[g-1]) top = g;
                            file_stop(f, f >= top);
                        end
                    end else if (heading == DIR_DOWN) begin
                        if (!beat.hall_dir) begin
                            bot = NUM_FLOORS + 1;
                            for (int g = NUM_FLOORS; g >= 1; g--)
                                if (down_map[g-1]) bot = g;
                            file_stop(f, !(f <= bot));
                        end else begin
                            file_stop(f, !(f <= car_at));
                        end
                    end else begin
                        file_stop(f, f >= car_at);
                    end
                end
            end
            CMD_OPEN: begin
                open_held = 1'b1;
            end
            CMD_CLOSE: begin
                close_held = 1'b1;
            end
            default: ;
        endcase
        st = '0;
        st.cur_floor    = FLOOR_W'(car_at);
        st.travel_dir   = heading;
        st.door_is_open = (car_phase == CAR_DOOR);
        st.in_motion    = (car_phase == CAR_MOVING);
        st.up_pending[NUM_FLOORS-1:0]   = up_map;
        st.down_pending[NUM_FLOORS-1:0] = down_map;
        st.event_res    = ev;
        return st;
    endfunction

    function automatic ecs_in_t mk_beat(input logic [2:0] cmd, input int f, input bit hd);
        ecs_in_t b;
        b.cmd       = cmd;
        b.req_floor = FLOOR_W'(f);
        b.hall_dir  = hd;
        return b;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            if (mismatch_count < REPORT_CAP)
                $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // driver: hold a beat until taken, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) status_q.push_back(advance_car(s_data));
            if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= beat_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: check each status beat, drive receiver back-pressure
    always @(posedge aclk) begin
        ecs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                if (mismatch_count < REPORT_CAP)
                    $display("%0t: unexpected status beat, expected none got %h",
                             $time, m_data);
                mismatch_count++;
            end else begin
                want = status_q.pop_front();
                check_field("cur_floor", want.cur_floor, m_data.cur_floor);
                check_field("travel_dir", want.travel_dir, m_data.travel_dir);
                check_field("door_is_open", want.door_is_open, m_data.door_is_open);
                check_field("in_motion", want.in_motion, m_data.in_motion);
                check_field("up_pending", want.up_pending, m_data.up_pending);
                check_field("down_pending", want.down_pending, m_data.down_pending);
                check_field("event_res", want.event_res, m_data.event_res);
            end
        end
        if (stall_request != stall_served) begin
            stall_served <= stall_request;
            stall_left   <= STALL_CYCLES;
            m_ready      <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (beat_q.size() != 0 || s_valid || status_q.size() != 0);
    endtask

    task automatic queue_random(input int count);
        ecs_in_t b;
        int      r;
        @(negedge aclk);
        repeat (count) begin
            r           = $urandom_range(0, 99);
            b.req_floor = FLOOR_W'($urandom_range(1, NUM_FLOORS));
            b.hall_dir  = 1'($urandom_range(0, 1));
            if (r < 52) begin
                b.cmd = CMD_TICK;
            end else if (r < 68) begin
                b.cmd = CMD_CAR;
            end else if (r < 84) begin
                b.cmd = CMD_HALL;
            end else if (r < 91) begin
                b.cmd = CMD_OPEN;
            end else if (r < 96) begin
                b.cmd = CMD_CLOSE;
            end else if (r < 98) begin
                b.cmd       = ($urandom_range(0, 1) != 0) ? CMD_CAR : CMD_HALL;
                b.req_floor = FLOOR_W'($urandom_range(0, 31));
            end else begin
                b.cmd       = 3'($urandom_range(5, 7));
                b.req_floor = FLOOR_W'($urandom_range(0, 31));
            end
            beat_q.push_back(b);
        end
    endtask

    task automatic run_phase(input logic [7:0] mv, input logic [7:0] dr, input logic [7:0] hm,
                             input int sp, input int rp, input int count,
                             input bit pause_mid, input bit stall_mid);
        write_reg(REG_MOVE_TICKS, mv);
        write_reg(REG_DOOR_TICKS, dr);
        write_reg(REG_HOME_FLOOR, hm);
        @(posedge aclk);
        send_idle_pct <= sp;
        recv_idle_pct <= rp;
        if (pause_mid) begin
            queue_random(count / 2);
            wait_drained();
            queue_random(count - count / 2);
        end else begin
            queue_random(count);
        end
        if (stall_mid) begin
            @(posedge aclk);
            stall_request <= stall_request + 1;
        end
        wait_drained();
    endtask

    initial begin
        reset_car();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct <= 18;
        recv_idle_pct <= 69;

        @(negedge aclk);
        beat_q.push_back(mk_beat(CMD_TICK, 3, 0));
        beat_q.push_back(mk_beat(CMD_CAR, 0, 0));
        beat_q.push_back(mk_beat(CMD_CAR, NUM_FLOORS + 1, 0));
        beat_q.push_back(mk_beat(CMD_CAR, 31, 1));
        beat_q.push_back(mk_beat(3'd5, 16, 0));
        beat_q.push_back(mk_beat(3'd6, 2, 1));
        beat_q.push_back(mk_beat(3'd7, 31, 1));
        beat_q.push_back(mk_beat(CMD_CAR, NUM_FLOORS, 0));
        beat_q.push_back(mk_beat(CMD_CAR, 1, 1));
        beat_q.push_back(mk_beat(CMD_HALL, 5, 1));
        beat_q.push_back(mk_beat(CMD_HALL, 2, 0));
        beat_q.push_back(mk_beat(CMD_HALL, 0, 1));
        beat_q.push_back(mk_beat(CMD_OPEN, 0, 0));
        beat_q.push_back(mk_beat(CMD_CLOSE, 0, 0));
        beat_q.push_back(mk_beat(CMD_TICK, 0, 0));
        beat_q.push_back(mk_beat(CMD_TICK, 0, 0));
        beat_q.push_back(mk_beat(CMD_TICK, 0, 0));
        repeat (5) beat_q.push_back(mk_beat(CMD_TICK, 0, 0));
        beat_q.push_back(mk_beat(CMD_HALL, NUM_FLOORS, 1));
        beat_q.push_back(mk_beat(CMD_CAR, 3, 0));
        beat_q.push_back(mk_beat(CMD_TICK, 0, 0));
        wait_drained();

        run_phase(8'd1, 8'd1, 8'd0, 18, 69, 110, 1'b0, 1'b0);
        run_phase(8'd0, 8'd3, 8'd8, 18, 69, 110, 1'b1, 1'b1);
        run_phase(8'd3, 8'd2, 8'hE5, 69, 18, 110, 1'b0, 1'b0);
        run_phase(8'd255, 8'd255, 8'd31, 69, 18, 60, 1'b0, 1'b0);
        run_phase(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                  8'($urandom_range(0, 255)), 0, 0, 130, 1'b0, 1'b0);
        run_phase(8'd2, 8'd0, 8'd1, 0, 0, 130, 1'b0, 1'b0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && status_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/ecs_pkg.sv
hdl/ecs_core.sv
hdl/elevator_call_scheduler_unit.sv
bench/tb_elevator_call_scheduler_unit.sv
